// ===== rtl/vtc_pkg.sv =====
// Shared types and constants of the virtual translation cache.
// Entry layout, request and register codes, and the slot wrap helper.
// No dependencies.
package vtc_pkg;

   localparam int ENTRIES    = 64;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int ADDR_W     = 64;
   localparam int BASE_W     = 61;
   localparam int SPACE_W    = 10;
   localparam int PAGE_W     = 6;
   localparam int PROT_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [ADDR_W-1:0] KEY_TAG_MASK    = 64'h7FFF_FFFF_FFFF_FE00;
   localparam logic [PAGE_W-1:0] PAGE_SIZE_RESET = 6'd13;

   typedef enum logic [1:0] {
      REQ_TRANSLATE = 2'd0,
      REQ_STORE     = 2'd1,
      REQ_UPDATE    = 2'd2,
      REQ_CLEAR     = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAGE_SIZE  = 1'b0,
      CSR_ADDR_SPACE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  tag;
      logic [SPACE_W-1:0] space;
      logic [BASE_W-1:0]  phys_base;
      logic [PROT_W-1:0]  prot;
   } entry_type;

   typedef struct packed {
      logic             rd_en;
      logic             rd_cache;
      logic [IDX_W-1:0] rd_slot;
      logic             wr_en;
      logic             wr_cache;
      logic [IDX_W-1:0] wr_slot;
      logic             clr_en;
      logic             clr_cache;
   } ram_ctl_type;

   function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] slot);
      logic [IDX_W-1:0] nxt;
      if (slot == IDX_W'(ENTRIES - 1)) begin
         nxt = '0;
      end else begin
         nxt = slot + 1'b1;
      end
      return nxt;
   endfunction

endpackage

// ===== rtl/vtc_entry_store.sv =====
// Entry memory of both caches with a registered read port and per-entry valid bits.
// Depends on vtc_pkg for the entry layout and the control struct.
module vtc_entry_store (
   input  logic                clock,
   input  logic                reset,
   input  vtc_pkg::ram_ctl_type ctl,
   input  vtc_pkg::entry_type  wr_data,
   output vtc_pkg::entry_type  rd_data,
   output logic                rd_valid
);
   import vtc_pkg::*;

   entry_type            mem_ff [2][ENTRIES];
   entry_type            rd_data_ff;
   logic [ENTRIES-1:0]   valid_ff [2];
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[ctl.wr_cache][ctl.wr_slot] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[ctl.rd_cache][ctl.rd_slot];
      end
   end

   // A clear drops the valid bits of one cache at once; the memory keeps stale data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= '0;
         valid_ff[1] <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.clr_en) begin
            valid_ff[ctl.clr_cache] <= '0;
         end
         if (ctl.wr_en) begin
            valid_ff[ctl.wr_cache][ctl.wr_slot] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[ctl.rd_cache][ctl.rd_slot];
         end
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

// ===== rtl/vtc_match.sv =====
// Shared compare and add unit: checks one entry against the search key and
// forms physical base plus page offset. Depends on vtc_pkg.
module vtc_match (
   input  vtc_pkg::entry_type                  entry,
   input  logic                                entry_valid,
   input  logic [vtc_pkg::ADDR_W-1:0]          key_tag,
   input  logic [vtc_pkg::SPACE_W-1:0]         key_space,
   input  logic [vtc_pkg::ADDR_W-1:0]          offset,
   output logic                                match,
   output logic [vtc_pkg::ADDR_W-1:0]          phys_sum
);
   import vtc_pkg::*;

   // An entry with protection zero counts as invalid.
   assign match = entry_valid && (entry.prot != '0) && (entry.space == key_space)
                  && (entry.tag == key_tag);

   assign phys_sum = {{(ADDR_W - BASE_W){1'b0}}, entry.phys_base} + offset;

endmodule

// ===== rtl/virtual_translation_cache.sv =====
// Virtual translation cache: a data and an instruction translation cache of
// ENTRIES entries each, round-robin replacement, one request at a time. A
// translate scans the selected cache from its newest entry, one entry per
// cycle through the single memory read port and a shared compare unit, and
// stops at the first valid match, or after all ENTRIES entries on a miss. An
// update scans both caches in turn and adds a write for each cache that
// matches. Store and clear pass through the write state only; clear drops
// the valid bits of one cache at once, so no clearing pass follows reset. A
// finished result waits in the output register while the next request is
// taken. The configuration registers may be written only while idle.
module virtual_translation_cache (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [vtc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vtc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_type,
   input  logic                             req_cache_select,
   input  logic [63:0]                      req_virt_address,
   input  logic [63:0]                      req_phys_address,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_hit,
   output logic [63:0]                      rsp_phys_out,
   output logic [2:0]                       rsp_protection,
   output logic [1:0]                       rsp_found_mask
);
   import vtc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [PAGE_W-1:0]    page_size_ff;
   logic [SPACE_W-1:0]   space_ff;

   req_kind_type         kind_ff, kind_in;
   logic                 cache_ff, cache_in;
   logic [ADDR_W-1:0]    offset_ff, offset_in;
   logic [ADDR_W-1:0]    key_tag_ff, key_tag_in;
   logic [SPACE_W-1:0]   key_space_ff, key_space_in;
   logic [BASE_W-1:0]    base_ff, base_in;
   logic [PROT_W-1:0]    new_prot_ff, new_prot_in;

   logic                 cur_cache_ff, cur_cache_in;
   logic [IDX_W-1:0]     slot_ptr_ff, slot_ptr_in;
   logic [CNT_W-1:0]     issue_cnt_ff, issue_cnt_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic                 rd_last_ff, rd_last_in;
   logic [IDX_W-1:0]     rd_slot_ff, rd_slot_in;
   logic [IDX_W-1:0]     match_slot_ff, match_slot_in;
   entry_type            match_entry_ff, match_entry_in;
   logic [IDX_W-1:0]     newest_ff [2];
   logic [IDX_W-1:0]     newest_in [2];

   logic                 res_hit_ff, res_hit_in;
   logic [ADDR_W-1:0]    res_phys_ff, res_phys_in;
   logic [PROT_W-1:0]    res_prot_ff, res_prot_in;
   logic [1:0]           res_found_ff, res_found_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [ADDR_W-1:0]    rsp_phys_ff, rsp_phys_in;
   logic [PROT_W-1:0]    rsp_prot_ff, rsp_prot_in;
   logic [1:0]           rsp_found_ff, rsp_found_in;

   ram_ctl_type          ram_ctl;
   entry_type            wr_data;
   entry_type            rd_entry;
   logic                 rd_entry_valid;
   logic                 hit_m;
   logic [ADDR_W-1:0]    sum_m;
   logic [ADDR_W-1:0]    page_mask;
   logic                 issue;
   logic                 stop;

   vtc_entry_store u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ram_ctl),
      .wr_data  (wr_data),
      .rd_data  (rd_entry),
      .rd_valid (rd_entry_valid)
   );

   vtc_match u_match (
      .entry       (rd_entry),
      .entry_valid (rd_entry_valid),
      .key_tag     (key_tag_ff),
      .key_space   (key_space_ff),
      .offset      (offset_ff),
      .match       (hit_m),
      .phys_sum    (sum_m)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff <= PAGE_SIZE_RESET;
         space_ff     <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PAGE_SIZE:  page_size_ff <= csr_wdata[PAGE_W-1:0];
            CSR_ADDR_SPACE: space_ff     <= csr_wdata[SPACE_W-1:0];
            default: ;
         endcase
      end
   end

   assign page_mask = ~({ADDR_W{1'b1}} << page_size_ff);
   // No request is taken while reset is held.
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign issue     = (issue_cnt_ff != CNT_W'(ENTRIES));
   assign stop      = rd_pend_ff && (hit_m || rd_last_ff);

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      cache_in       = cache_ff;
      offset_in      = offset_ff;
      key_tag_in     = key_tag_ff;
      key_space_in   = key_space_ff;
      base_in        = base_ff;
      new_prot_in    = new_prot_ff;
      cur_cache_in   = cur_cache_ff;
      slot_ptr_in    = slot_ptr_ff;
      issue_cnt_in   = issue_cnt_ff;
      rd_pend_in     = 1'b0;
      rd_last_in     = rd_last_ff;
      rd_slot_in     = rd_slot_ff;
      match_slot_in  = match_slot_ff;
      match_entry_in = match_entry_ff;
      newest_in[0]   = newest_ff[0];
      newest_in[1]   = newest_ff[1];
      res_hit_in     = res_hit_ff;
      res_phys_in    = res_phys_ff;
      res_prot_in    = res_prot_ff;
      res_found_in   = res_found_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_phys_in    = rsp_phys_ff;
      rsp_prot_in    = rsp_prot_ff;
      rsp_found_in   = rsp_found_ff;
      ram_ctl        = '0;
      wr_data        = match_entry_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in      = req_kind_type'(req_type);
               cache_in     = req_cache_select;
               offset_in    = req_virt_address & page_mask;
               base_in      = req_phys_address[BASE_W-1:0] & ~page_mask[BASE_W-1:0];
               res_hit_in   = 1'b0;
               res_phys_in  = '0;
               res_prot_in  = '0;
               res_found_in = '0;
               issue_cnt_in = '0;
               if (req_kind_type'(req_type) == REQ_UPDATE) begin
                  key_tag_in   = req_virt_address & KEY_TAG_MASK;
                  key_space_in = req_virt_address[SPACE_W+2:3];
                  new_prot_in  = req_virt_address[PROT_W-1:0];
                  cur_cache_in = 1'b0;
                  slot_ptr_in  = newest_ff[0];
               end else begin
                  key_tag_in   = req_virt_address & ~page_mask;
                  key_space_in = space_ff;
                  new_prot_in  = req_phys_address[PROT_W-1:0] & page_mask[PROT_W-1:0];
                  cur_cache_in = req_cache_select;
                  slot_ptr_in  = newest_ff[req_cache_select];
               end
               unique case (req_kind_type'(req_type))
                  REQ_TRANSLATE, REQ_UPDATE: state_in = ST_SCAN;
                  default:                   state_in = ST_WRITE;
               endcase
            end
         end

         ST_SCAN: begin
            // Reads run one entry ahead of the compare; no read is issued in the
            // cycle that finds the answer.
            if (issue && !stop) begin
               ram_ctl.rd_en    = 1'b1;
               ram_ctl.rd_cache = cur_cache_ff;
               ram_ctl.rd_slot  = slot_ptr_ff;
               slot_ptr_in      = slot_inc(slot_ptr_ff);
               issue_cnt_in     = issue_cnt_ff + 1'b1;
               rd_slot_in       = slot_ptr_ff;
               rd_last_in       = (issue_cnt_ff == CNT_W'(ENTRIES - 1));
               rd_pend_in       = 1'b1;
            end
            if (stop) begin
               if (hit_m) begin
                  if (kind_ff == REQ_UPDATE) begin
                     match_slot_in  = rd_slot_ff;
                     match_entry_in = rd_entry;
                     if (cur_cache_ff) begin
                        res_found_in[0] = 1'b1;
                     end else begin
                        res_found_in[1] = 1'b1;
                     end
                     state_in = ST_WRITE;
                  end else begin
                     res_hit_in  = 1'b1;
                     res_phys_in = sum_m;
                     res_prot_in = rd_entry.prot;
                     state_in    = ST_DONE;
                  end
               end else if (kind_ff == REQ_UPDATE && !cur_cache_ff) begin
                  cur_cache_in = 1'b1;
                  slot_ptr_in  = newest_ff[1];
                  issue_cnt_in = '0;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_WRITE: begin
            state_in = ST_DONE;
            case (kind_ff)
               REQ_STORE: begin
                  ram_ctl.wr_en     = 1'b1;
                  ram_ctl.wr_cache  = cache_ff;
                  ram_ctl.wr_slot   = slot_inc(newest_ff[cache_ff]);
                  newest_in[cache_ff] = slot_inc(newest_ff[cache_ff]);
                  wr_data.tag       = key_tag_ff;
                  wr_data.space     = key_space_ff;
                  wr_data.phys_base = base_ff;
                  wr_data.prot      = new_prot_ff;
               end
               REQ_CLEAR: begin
                  ram_ctl.clr_en    = 1'b1;
                  ram_ctl.clr_cache = cache_ff;
               end
               REQ_UPDATE: begin
                  ram_ctl.wr_en    = 1'b1;
                  ram_ctl.wr_cache = cur_cache_ff;
                  ram_ctl.wr_slot  = match_slot_ff;
                  wr_data.prot     = new_prot_ff;
                  if (!cur_cache_ff) begin
                     cur_cache_in = 1'b1;
                     slot_ptr_in  = newest_ff[1];
                     issue_cnt_in = '0;
                     state_in     = ST_SCAN;
                  end
               end
               default: ;
            endcase
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_phys_in  = res_phys_ff;
               rsp_prot_in  = res_prot_ff;
               rsp_found_in = res_found_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_cnt_ff <= '0;
         rd_pend_ff   <= 1'b0;
         newest_ff[0] <= '0;
         newest_ff[1] <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_cnt_ff <= issue_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         newest_ff[0] <= newest_in[0];
         newest_ff[1] <= newest_in[1];
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff        <= kind_in;
      cache_ff       <= cache_in;
      offset_ff      <= offset_in;
      key_tag_ff     <= key_tag_in;
      key_space_ff   <= key_space_in;
      base_ff        <= base_in;
      new_prot_ff    <= new_prot_in;
      cur_cache_ff   <= cur_cache_in;
      slot_ptr_ff    <= slot_ptr_in;
      rd_last_ff     <= rd_last_in;
      rd_slot_ff     <= rd_slot_in;
      match_slot_ff  <= match_slot_in;
      match_entry_ff <= match_entry_in;
      res_hit_ff     <= res_hit_in;
      res_phys_ff    <= res_phys_in;
      res_prot_ff    <= res_prot_in;
      res_found_ff   <= res_found_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_phys_ff    <= rsp_phys_in;
      rsp_prot_ff    <= rsp_prot_in;
      rsp_found_ff   <= rsp_found_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_phys_out   = rsp_phys_ff;
   assign rsp_protection = rsp_prot_ff;
   assign rsp_found_mask = rsp_found_ff;

`ifndef SYNTHESIS
   a_hit_has_prot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_protection != 3'd0 && rsp_found_mask == 2'd0))
      else $error("hit delivered with zero protection or a found mask");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_phys_out == 64'd0 && rsp_protection == 3'd0))
      else $error("miss delivered with nonzero translation fields");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (!ram_ctl.wr_en && !ram_ctl.clr_en))
      else $error("memory written during a scan");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      issue_cnt_ff <= CNT_W'(ENTRIES))
      else $error("scan issued more reads than entries");

   a_read_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> $past(state_ff == ST_SCAN))
      else $error("read pending without a scan in the previous cycle");
`endif

endmodule
